[rtl/positional_list_insert_delete_defines.svh]
// ---------------------------------------------------------------------------
// Assertion macros used by the checker file of the list block.
// ---------------------------------------------------------------------------
`ifndef POSITIONAL_LIST_INSERT_DELETE_DEFINES_SVH
`define POSITIONAL_LIST_INSERT_DELETE_DEFINES_SVH

// Same-cycle implication, held off while reset is asserted.
`define PLI_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, held off while reset is asserted.
`define PLI_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/pli_pkg.sv]
// ---------------------------------------------------------------------------
// pli_pkg
// Types and codes shared by the positional list cells, gather tree and top.
// ---------------------------------------------------------------------------
package pli_pkg;

  localparam int WORD_W = 32;
  localparam int POS_W  = 16;
  localparam int KIND_W = 3;
  localparam int LEN_W  = 9;

  typedef logic [WORD_W-1:0] word_t;
  typedef logic [POS_W-1:0]  pos_t;
  typedef logic [KIND_W-1:0] kind_t;
  typedef logic [LEN_W-1:0]  len_t;

  localparam kind_t KIND_READ = 3'd0;
  localparam kind_t KIND_HEAD = 3'd1;
  localparam kind_t KIND_TAIL = 3'd2;
  localparam kind_t KIND_AT   = 3'd3;
  localparam kind_t KIND_DEL  = 3'd4;

  // Control broadcast to every cell of the chain.
  typedef struct packed {
    logic ins;
    logic del;
    pos_t pos;
  } cell_ctl_t;

endpackage

[rtl/positional_list_insert_delete.sv]
// ---------------------------------------------------------------------------
// positional_list_insert_delete
// Bounded ordered list of signed 32-bit words held in a chain of cells.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall / in_kind, in_position, in_data_in)
//   carries one request: read, insert at head, insert at tail, insert at a
//   position, or delete at a position. Each request gives exactly one result
//   on the output channel (out_valid / out_stall / out_read_data,
//   out_applied, out_full_reject, out_list_length).
//   A request passes the execute and gather states, then the output
//   register. The block holds one request at a time and takes no new
//   one until the last result is loaded; the gather state waits on the
//   registered gather tree that collects the addressed cell's word for a read.
//   Insert and delete shift every later cell by one place at once.
//   Reset clears the element count and the handshake state; cell contents
//   are left as they are and no clearing pass is run.
//   While the receiver stalls, the finished result waits in the output
//   register and the next request is still accepted and worked on; its
//   result is held back until the output register is free.
// ---------------------------------------------------------------------------
module positional_list_insert_delete #(
  parameter int CAPACITY = 256
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  pli_pkg::kind_t               in_kind,
  input  pli_pkg::pos_t                in_position,
  input  logic signed [pli_pkg::WORD_W-1:0] in_data_in,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic signed [pli_pkg::WORD_W-1:0] out_read_data,
  output logic                         out_applied,
  output logic                         out_full_reject,
  output pli_pkg::len_t                out_list_length
);
  import pli_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);

  // Control sequence: wait for a request, update the chain, gather the read.
  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_EXEC   = 2'd1;
  localparam logic [1:0] S_GATHER = 2'd2;

  logic [1:0]    state_r, state_nxt;
  logic [CW-1:0] count_r, count_nxt;

  // Latched request.
  kind_t op_kind_r;
  pos_t  op_pos_r;
  word_t op_data_r;

  // Outcome flags, settled in the execute cycle.
  logic rd_ok_r,   rd_ok_nxt;
  logic applied_r, applied_nxt;
  logic reject_r,  reject_nxt;

  // Output register.
  logic  out_valid_r, out_valid_nxt;
  word_t out_read_data_r;
  logic  out_applied_r;
  logic  out_full_reject_r;
  len_t  out_list_length_r;

  logic      accept;
  logic      load_out;
  logic      is_ins;
  logic      full;
  logic      ins_ok, del_ok, rd_ok;
  pos_t      cnt_pos;
  pos_t      eff_pos;
  cell_ctl_t ctl;
  word_t     gathered;

  word_t values [CAPACITY];
  word_t taps   [CAPACITY];

  assign in_stall = !rst_n || (state_r != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign load_out = (state_r == S_GATHER) && (!out_valid_r || !out_stall);

  // Decode the latched request against the current length.
  assign cnt_pos = pos_t'(count_r);
  assign full    = (count_r == CW'(CAPACITY));

  always_comb begin
    is_ins  = 1'b0;
    eff_pos = op_pos_r;
    unique case (op_kind_r) inside
      KIND_HEAD: begin
        is_ins  = 1'b1;
        eff_pos = '0;
      end
      KIND_TAIL: begin
        is_ins  = 1'b1;
        eff_pos = cnt_pos;
      end
      KIND_AT: begin
        is_ins = 1'b1;
      end
      default: begin
        is_ins = 1'b0;
      end
    endcase
  end

  // Insert is refused on a full list whatever the position.
  assign ins_ok = is_ins && !full && (eff_pos <= cnt_pos);
  assign del_ok = (op_kind_r == KIND_DEL) && (op_pos_r < cnt_pos);
  assign rd_ok  = (op_kind_r == KIND_READ) && (op_pos_r < cnt_pos);

  // Broadcast to the chain; shifts happen only in the execute cycle.
  always_comb begin
    ctl.ins = ins_ok && (state_r == S_EXEC);
    ctl.del = del_ok && (state_r == S_EXEC);
    ctl.pos = eff_pos;
  end

  // Chain of cells, each wired to its two neighbours.
  for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
    word_t left_w;
    word_t right_w;

    if (k == 0) begin : g_first
      assign left_w = op_data_r;
    end else begin : g_left
      assign left_w = values[k-1];
    end

    if (k == CAPACITY - 1) begin : g_last
      assign right_w = values[k];
    end else begin : g_right
      assign right_w = values[k+1];
    end

    pli_cell #(
      .IDX (k)
    ) u_cell (
      .clk   (clk),
      .ctl   (ctl),
      .data  (op_data_r),
      .left  (left_w),
      .right (right_w),
      .value (values[k]),
      .tap   (taps[k])
    );
  end

  pli_gather #(
    .N (CAPACITY)
  ) u_gather (
    .clk    (clk),
    .taps   (taps),
    .result (gathered)
  );

  // Sequencer and length.
  always_comb begin
    state_nxt   = state_r;
    count_nxt   = count_r;
    rd_ok_nxt   = rd_ok_r;
    applied_nxt = applied_r;
    reject_nxt  = reject_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        rd_ok_nxt   = rd_ok;
        applied_nxt = ins_ok || del_ok || rd_ok;
        reject_nxt  = is_ins && full;
        if (ins_ok) begin
          count_nxt = count_r + CW'(1);
        end else if (del_ok) begin
          count_nxt = count_r - CW'(1);
        end
        state_nxt = S_GATHER;
      end
      S_GATHER: begin
        // hold here until the output register can take the result
        if (load_out) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
      rd_ok_r     <= 1'b0;
      applied_r   <= 1'b0;
      reject_r    <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
      rd_ok_r     <= rd_ok_nxt;
      applied_r   <= applied_nxt;
      reject_r    <= reject_nxt;
    end
  end

  // Request and result payload: no reset needed.
  always_ff @(posedge clk) begin
    if (accept) begin
      op_kind_r <= in_kind;
      op_pos_r  <= in_position;
      op_data_r <= word_t'(in_data_in);
    end
    if (load_out) begin
      out_read_data_r   <= rd_ok_r ? gathered : '1;
      out_applied_r     <= applied_r;
      out_full_reject_r <= reject_r;
      out_list_length_r <= len_t'(count_r);
    end
  end

  assign out_valid       = out_valid_r;
  assign out_read_data   = $signed(out_read_data_r);
  assign out_applied     = out_applied_r;
  assign out_full_reject = out_full_reject_r;
  assign out_list_length = out_list_length_r;

endmodule

[rtl/pli_cell.sv]
// ---------------------------------------------------------------------------
// pli_cell
// One list slot: takes from the left on insert, from the right on delete.
// ---------------------------------------------------------------------------
module pli_cell #(
  parameter int IDX = 0
) (
  input  logic              clk,
  input  pli_pkg::cell_ctl_t ctl,
  input  pli_pkg::word_t    data,
  input  pli_pkg::word_t    left,
  input  pli_pkg::word_t    right,
  output pli_pkg::word_t    value,
  output pli_pkg::word_t    tap
);
  import pli_pkg::*;

  localparam pos_t K = pos_t'(IDX);

  word_t value_r;
  word_t value_nxt;

  always_comb begin
    value_nxt = value_r;
    if (ctl.ins && (K >= ctl.pos)) begin
      value_nxt = (K == ctl.pos) ? data : left;
    end else if (ctl.del && (K >= ctl.pos)) begin
      value_nxt = right;
    end
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
  end

  assign value = value_r;
  // drive the slot onto the gather tree only when it is the addressed one
  assign tap   = (K == ctl.pos) ? value_r : '0;

endmodule

[rtl/pli_gather.sv]
// ---------------------------------------------------------------------------
// pli_gather
// Two-level OR tree over the cell taps; first level registered per group.
// ---------------------------------------------------------------------------
module pli_gather #(
  parameter int N = 256
) (
  input  logic           clk,
  input  pli_pkg::word_t taps [N],
  output pli_pkg::word_t result
);
  import pli_pkg::*;

  localparam int HALF = ($clog2(N) + 1) / 2;
  localparam int G    = 1 << HALF;
  localparam int NG   = (N + G - 1) / G;

  word_t pad   [NG*G];
  word_t part_r [NG];
  word_t part_nxt [NG];

  for (genvar i = 0; i < NG*G; i++) begin : g_pad
    if (i < N) begin : g_real
      assign pad[i] = taps[i];
    end else begin : g_zero
      assign pad[i] = '0;
    end
  end

  for (genvar g = 0; g < NG; g++) begin : g_grp
    always_comb begin
      part_nxt[g] = '0;
      for (int j = 0; j < G; j++) begin
        part_nxt[g] = part_nxt[g] | pad[g*G + j];
      end
    end

    always_ff @(posedge clk) begin
      part_r[g] <= part_nxt[g];
    end
  end

  always_comb begin
    result = '0;
    for (int g = 0; g < NG; g++) begin
      result = result | part_r[g];
    end
  end

endmodule

[rtl/pli_checker.sv]
// ---------------------------------------------------------------------------
// pli_checker
// Port-level checks on the positional list, bound to the top level.
// ---------------------------------------------------------------------------
`include "positional_list_insert_delete_defines.svh"

module pli_checker #(
  parameter int CAPACITY = 256
) (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_valid,
  input logic                         in_stall,
  input logic                         out_valid,
  input logic                         out_stall,
  input logic signed [pli_pkg::WORD_W-1:0] out_read_data,
  input logic                         out_applied,
  input logic                         out_full_reject,
  input pli_pkg::len_t                out_list_length
);
  import pli_pkg::*;

  logic                    taken;
  logic                    held;
  logic                    refused;
  logic                    missed;
  logic                    at_cap;
  logic [WORD_W+LEN_W+1:0] res_bus;

  assign taken   = in_valid && !in_stall;
  assign held    = out_valid && out_stall;
  assign refused = out_valid && out_full_reject;
  assign missed  = out_valid && !out_applied;
  assign at_cap  = (out_list_length == len_t'(CAPACITY));
  assign res_bus = {out_read_data, out_applied, out_full_reject, out_list_length};

  // a stalled result stays offered
  `PLI_ASSERT_NEXT(a_out_hold, clk, rst_n, held, out_valid, "result dropped while stalled")

  // a stalled result does not change
  `PLI_ASSERT_NEXT(a_out_stable, clk, rst_n, held, $stable(res_bus), "stalled result changed")

  // one request in flight: a new request is not taken the cycle after one
  `PLI_ASSERT_NEXT(a_one_inflight, clk, rst_n, taken, in_stall, "request taken back to back")

  // a refused insert leaves the list full and reports nothing applied
  `PLI_ASSERT_IMPL(a_reject_full, clk, rst_n, refused, !out_applied && at_cap, "refused below capacity")

  // nothing applied means no element read
  `PLI_ASSERT_IMPL(a_miss_value, clk, rst_n, missed, out_read_data == '1, "miss without all ones")

endmodule

bind positional_list_insert_delete pli_checker #(
  .CAPACITY (CAPACITY)
) u_pli_checker (.*);
